/* rtl/vam_pkg.sv */
// Package for the vector align rotation matrix unit.
// Holds the fixed-point widths, the pipeline depths and the saturation helper.
// No dependencies.
package vam_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DW        = 16;

  // First-stage products and sums
  localparam int P_W  = 2 * DW;
  localparam int VF_W = P_W + 1;
  localparam int C_W  = P_W + 2;
  localparam int D_W  = ((2 * FRAC_BITS > C_W) ? 2 * FRAC_BITS : C_W) + 2;
  localparam int DU_W = D_W - 1;

  // Rounded cross product and its products
  localparam int V_W  = 34 - FRAC_BITS;
  localparam int VV_W = 2 * V_W;
  localparam int M_W  = VV_W + 1;

  // Identity plus skew entry
  localparam int B_W = ((V_W > FRAC_BITS + 1) ? V_W : FRAC_BITS + 1) + 2;

  // Quotient bits; anything at or above 2^QB saturates the entry anyway
  localparam int QB0 = (V_W > FRAC_BITS + 2) ? V_W : FRAC_BITS + 2;
  localparam int QB  = ((QB0 > 16) ? QB0 : 16) + 1;

  localparam int N_W     = M_W + FRAC_BITS + 1;
  localparam int R_W     = ((N_W > D_W + QB) ? N_W : D_W + QB) + 1;
  localparam int QS_W    = QB + 2;
  localparam int M_OUT_W = ((QS_W > B_W) ? QS_W : B_W) + 2;

  localparam int LAT_FRONT = 5;
  localparam int LAT_DIV   = QB + 2;
  localparam int LAT       = LAT_FRONT + LAT_DIV;

  localparam logic signed [DW-1:0] ID_DIAG =
    (FRAC_BITS >= DW - 1) ? 16'sh7FFF : DW'(1 << FRAC_BITS);

  function automatic logic signed [DW-1:0] sat16(input logic signed [M_OUT_W-1:0] x);
    logic signed [M_OUT_W-1:0] hi;
    logic signed [M_OUT_W-1:0] lo;
    hi = M_OUT_W'(32767);
    lo = -M_OUT_W'(32768);
    if (x > hi) begin
      return 16'sh7FFF;
    end else if (x < lo) begin
      return 16'sh8000;
    end
    return DW'(x);
  endfunction

endpackage

/* rtl/vam_if.sv */
// Channel interfaces for the vector align rotation matrix unit.
// Depends on vam_pkg for the field width.
interface vam_pair_if import vam_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [DW-1:0] a_x;
  logic signed [DW-1:0] a_y;
  logic signed [DW-1:0] a_z;
  logic signed [DW-1:0] b_x;
  logic signed [DW-1:0] b_y;
  logic signed [DW-1:0] b_z;
  modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface vam_rot_if import vam_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [DW-1:0] r00;
  logic signed [DW-1:0] r01;
  logic signed [DW-1:0] r02;
  logic signed [DW-1:0] r10;
  logic signed [DW-1:0] r11;
  logic signed [DW-1:0] r12;
  logic signed [DW-1:0] r20;
  logic signed [DW-1:0] r21;
  logic signed [DW-1:0] r22;
  logic degenerate;
  modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, degenerate,
                 input ready);
  modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, degenerate,
               output ready);
endinterface

/* rtl/vector_align_rotation_matrix_unit.sv */
// Rotation matrix that turns vector a onto vector b: R = I + K + K*K/(1+a.b).
// Takes one request per cycle while the output is not stalled.
// The depth is set by the restoring divider, one quotient bit per stage.
// The whole pipeline holds while a finished result waits; nothing is lost.
// Synchronous active-high reset clears the valid bits only.
module vector_align_rotation_matrix_unit import vam_pkg::*; (
  input logic       clk,
  input logic       rst,
  vam_pair_if.sink  pair,
  vam_rot_if.source rot
);

  // Pipeline advance: move whenever the output stage is empty or drained.
  logic en;
  logic vld [LAT];
  logic dg  [LAT_DIV];

  assign en         = !vld[LAT-1] || rot.ready;
  assign pair.ready = en;

  logic signed [DW-1:0]  a [3];
  logic signed [DW-1:0]  b [3];
  logic signed [M_W-1:0] n [9];
  logic signed [B_W-1:0] base [9];
  logic [DU_W-1:0]       d;
  logic                  degen;
  logic signed [DW-1:0]  r [9];

  assign a[0] = pair.a_x;
  assign a[1] = pair.a_y;
  assign a[2] = pair.a_z;
  assign b[0] = pair.b_x;
  assign b[1] = pair.b_y;
  assign b[2] = pair.b_z;

  // Products, rounding of the cross product, K*K numerators and divisor.
  vam_front u_front (
    .clk  (clk),
    .en   (en),
    .a    (a),
    .b    (b),
    .n    (n),
    .base (base),
    .d    (d),
    .degen(degen)
  );

  // Nine pipelined dividers, one per matrix entry, row-major.
  for (genvar e = 0; e < 9; e++) begin : g_entry
    vam_div u_div (
      .clk (clk),
      .en  (en),
      .n   (n[e]),
      .d   (d),
      .base(base[e]),
      .r   (r[e])
    );
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= pair.valid;
      for (int i = 1; i < LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // Degenerate flag rides alongside the divider stages.
  always_ff @(posedge clk) begin
    if (en) begin
      dg[0] <= degen;
      for (int i = 1; i < LAT_DIV; i++) begin
        dg[i] <= dg[i-1];
      end
    end
  end

  assign rot.valid      = vld[LAT-1];
  assign rot.degenerate = dg[LAT_DIV-1];
  assign rot.r00 = r[0];
  assign rot.r01 = r[1];
  assign rot.r02 = r[2];
  assign rot.r10 = r[3];
  assign rot.r11 = r[4];
  assign rot.r12 = r[5];
  assign rot.r20 = r[6];
  assign rot.r21 = r[7];
  assign rot.r22 = r[8];

endmodule

/* rtl/vam_front.sv */
// Front end: cross and dot products, rounding, skew matrix and K*K numerators.
// Five register stages. Depends on vam_pkg.
module vam_front import vam_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [DW-1:0]  a [3],
  input  logic signed [DW-1:0]  b [3],
  output logic signed [M_W-1:0] n [9],
  output logic signed [B_W-1:0] base [9],
  output logic [DU_W-1:0]       d,
  output logic                  degen
);

  // S1
  logic signed [P_W-1:0] p [9];
  // S2
  logic signed [VF_W-1:0] vf [3];
  logic signed [D_W-1:0]  d2;
  logic                   dg2;
  // S3
  logic signed [V_W-1:0] v [3];
  logic [DU_W-1:0]       d3;
  logic                  dg3;
  // S4
  logic signed [VV_W-1:0] vv [6];
  logic signed [B_W-1:0]  base4 [9];
  logic [DU_W-1:0]        d4;
  logic                   dg4;

  logic signed [C_W-1:0]    c_sum;
  logic signed [D_W-1:0]    d_sum;
  logic signed [VF_W:0]     vr [3];
  logic signed [B_W-1:0]    one_b;

  always_comb begin
    c_sum = C_W'(p[6]) + C_W'(p[7]) + C_W'(p[8]);
    d_sum = D_W'(c_sum) + (D_W'(1) <<< (2 * FRAC_BITS));
    for (int i = 0; i < 3; i++) begin
      vr[i] = (VF_W + 1)'(vf[i]) + (VF_W + 1)'(1 <<< (FRAC_BITS - 1));
    end
    one_b = B_W'(1) <<< FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= a[1] * b[2];
      p[1] <= a[2] * b[1];
      p[2] <= a[2] * b[0];
      p[3] <= a[0] * b[2];
      p[4] <= a[0] * b[1];
      p[5] <= a[1] * b[0];
      p[6] <= a[0] * b[0];
      p[7] <= a[1] * b[1];
      p[8] <= a[2] * b[2];

      vf[0] <= VF_W'(p[0]) - VF_W'(p[1]);
      vf[1] <= VF_W'(p[2]) - VF_W'(p[3]);
      vf[2] <= VF_W'(p[4]) - VF_W'(p[5]);
      d2    <= d_sum;
      dg2   <= (d_sum <= 0);

      // degenerate: zero v and a unit divisor give the identity downstream
      for (int i = 0; i < 3; i++) begin
        v[i] <= dg2 ? '0 : V_W'(vr[i] >>> FRAC_BITS);
      end
      d3  <= dg2 ? DU_W'(1) : DU_W'(d2);
      dg3 <= dg2;

      vv[0] <= v[0] * v[0];
      vv[1] <= v[1] * v[1];
      vv[2] <= v[2] * v[2];
      vv[3] <= v[0] * v[1];
      vv[4] <= v[0] * v[2];
      vv[5] <= v[1] * v[2];
      base4[0] <= one_b;
      base4[1] <= -B_W'(v[2]);
      base4[2] <= B_W'(v[1]);
      base4[3] <= B_W'(v[2]);
      base4[4] <= one_b;
      base4[5] <= -B_W'(v[0]);
      base4[6] <= -B_W'(v[1]);
      base4[7] <= B_W'(v[0]);
      base4[8] <= one_b;
      d4  <= d3;
      dg4 <= dg3;

      n[0] <= -(M_W'(vv[1]) + M_W'(vv[2]));
      n[4] <= -(M_W'(vv[0]) + M_W'(vv[2]));
      n[8] <= -(M_W'(vv[0]) + M_W'(vv[1]));
      n[1] <= M_W'(vv[3]);
      n[3] <= M_W'(vv[3]);
      n[2] <= M_W'(vv[4]);
      n[6] <= M_W'(vv[4]);
      n[5] <= M_W'(vv[5]);
      n[7] <= M_W'(vv[5]);
      base  <= base4;
      d     <= d4;
      degen <= dg4;
    end
  end

endmodule

/* rtl/vam_div.sv */
// One matrix entry: rounded restoring division of n*2^F by d, one bit a stage,
// then identity plus skew added and the sum saturated. Depends on vam_pkg.
module vam_div import vam_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [M_W-1:0] n,
  input  logic [DU_W-1:0]       d,
  input  logic signed [B_W-1:0] base,
  output logic signed [DW-1:0]  r
);

  logic [R_W-1:0]        rem  [QB+1];
  logic [QB-1:0]         q    [QB+1];
  logic [DU_W-1:0]       dd   [QB+1];
  logic signed [B_W-1:0] bs   [QB+1];
  logic                  neg  [QB+1];
  logic                  ovf  [QB+1];

  logic [M_W-1:0]         mag;
  logic [R_W-1:0]         num;
  logic [QS_W-1:0]        full;
  logic signed [QS_W-1:0] qs;
  logic signed [M_OUT_W-1:0] m;

  always_comb begin
    mag  = (n < 0) ? M_W'(-n) : M_W'(n);
    num  = (R_W'(mag) << FRAC_BITS) + R_W'(d >> 1);
    full = ovf[QB] ? (QS_W'(1) << QB) : QS_W'(q[QB]);
    qs   = neg[QB] ? -$signed(full) : $signed(full);
    m    = M_OUT_W'(bs[QB]) + M_OUT_W'(qs);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      q[0]   <= '0;
      dd[0]  <= d;
      bs[0]  <= base;
      neg[0] <= (n < 0);
      ovf[0] <= (num >= (R_W'(d) << QB));
      r      <= sat16(m);
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = QB - 1 - j;
    logic [R_W-1:0] sub;
    assign sub = R_W'(dd[j]) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[j] >= sub) begin
          rem[j+1] <= rem[j] - sub;
          q[j+1]   <= q[j] | (QB'(1) << K);
        end else begin
          rem[j+1] <= rem[j];
          q[j+1]   <= q[j];
        end
        dd[j+1]  <= dd[j];
        bs[j+1]  <= bs[j];
        neg[j+1] <= neg[j];
        ovf[j+1] <= ovf[j];
      end
    end
  end

endmodule

/* rtl/vam_checker.sv */
// Port-level checks for the vector align rotation matrix unit, bound to the top.
// Depends on vam_pkg.
module vam_checker import vam_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 degenerate,
  input logic signed [DW-1:0] r00,
  input logic signed [DW-1:0] r01,
  input logic signed [DW-1:0] r11,
  input logic signed [DW-1:0] r12,
  input logic signed [DW-1:0] r22
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output drain");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |->
      (r00 == ID_DIAG && r11 == ID_DIAG && r22 == ID_DIAG && r01 == 0 && r12 == 0))
    else $error("degenerate result is not the identity");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(r01) && $stable(degenerate)))
    else $error("stalled result changed");

endmodule

bind vector_align_rotation_matrix_unit vam_checker u_vam_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pair.ready),
  .out_valid (rot.valid),
  .out_ready (rot.ready),
  .degenerate(rot.degenerate),
  .r00       (rot.r00),
  .r01       (rot.r01),
  .r11       (rot.r11),
  .r12       (rot.r12),
  .r22       (rot.r22)
);
